// File: design/aesbc_pkg.sv
// ----------------------------------------------------------------------------
// aesbc_pkg
// Shared types, register indexes and byte-level functions for the AES block
// cipher unit: forward and inverse S-box, xtime, column mixing.
// ----------------------------------------------------------------------------
package aesbc_pkg;

    localparam int NumCells = 4;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_KEYLEN = 3'd4,
        REG_DIR    = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_KEY   = 2'd1,
        ST_ROUND = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    // control from the sequencer to every column cell
    typedef struct packed {
        logic load;
        logic step;
        logic decrypt;
        logic last;
    } cell_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3, x;
        a0 = w[7:0]; a1 = w[15:8]; a2 = w[23:16]; a3 = w[31:24];
        x = a0 ^ a1 ^ a2 ^ a3;
        return {a3 ^ x ^ xtime(a3 ^ a0), a2 ^ x ^ xtime(a2 ^ a3),
                a1 ^ x ^ xtime(a1 ^ a2), a0 ^ x ^ xtime(a0 ^ a1)};
    endfunction

    // inverse mix as forward mix after a cheap pre-step
    function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = w[7:0]; a1 = w[15:8]; a2 = w[23:16]; a3 = w[31:24];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_word({a3 ^ v, a2 ^ u, a1 ^ v, a0 ^ u});
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

// File: design/aes_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_unit
// AES-128/192/256 ECB encrypt or decrypt, one 128-bit block per item.
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_        in   s_valid / s_ready   aesbc_pkg::in_item_t
// m_        out  m_valid / m_ready   aesbc_pkg::out_item_t
// cfg       in   cfg_we, cfg_index   cfg_data (64 bits)
//
// an item goes through key expansion, one word per cycle, then the rounds and
// then into the output register; no new item is taken until its result is in
// the output register, since the key expansion and the single round of four
// column cells serve one item at a time.
// reset clears control and the configuration registers; round keys are rebuilt for every item.
// a waiting result holds in the output register while the next item is taken;
// that item stalls after its last round until the register is free.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aesbc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output aesbc_pkg::out_item_t m_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [255:0]         key_reg;
    logic [1:0]           keylen_reg;
    logic                 dir_reg;
    aesbc_pkg::state_t    state_reg, state_next;
    logic [3:0]           round_reg, round_next;
    logic [127:0]         blk_reg;
    logic                 mvalid_reg, mvalid_next;
    aesbc_pkg::out_item_t res_reg;
    logic                 res_load;
    logic [127:0]         rk;
    logic                 ks_done, ks_start;
    logic [3:0]           nr;
    logic [31:0]          cols [aesbc_pkg::NumCells];
    logic [31:0]          shifted [aesbc_pkg::NumCells];
    aesbc_pkg::cell_ctrl_t ctrl;
    logic [1:0]           eff_len;

    assign eff_len = (keylen_reg == 2'd3) ? 2'd2 : keylen_reg;
    assign nr = 4'd10 + {1'b0, eff_len, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg    <= '0;
            keylen_reg <= '0;
            dir_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                aesbc_pkg::REG_KEY0:   key_reg[63:0]    <= cfg_data;
                aesbc_pkg::REG_KEY1:   key_reg[127:64]  <= cfg_data;
                aesbc_pkg::REG_KEY2:   key_reg[191:128] <= cfg_data;
                aesbc_pkg::REG_KEY3:   key_reg[255:192] <= cfg_data;
                aesbc_pkg::REG_KEYLEN: keylen_reg       <= cfg_data[1:0];
                aesbc_pkg::REG_DIR:    dir_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == aesbc_pkg::ST_IDLE);
    assign ks_start = s_valid && s_ready;

    aesbc_key_sched u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (ks_start),
        .key        (key_reg),
        .key_length (eff_len),
        .decrypt    (dir_reg),
        .rd_round   (round_reg),
        .rd_key     (rk),
        .done       (ks_done)
    );

    always_ff @(posedge aclk) begin
        if (ks_start) begin
            blk_reg <= s_data;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        case (state_reg)
            aesbc_pkg::ST_IDLE: begin
                if (ks_start) begin
                    state_next = aesbc_pkg::ST_KEY;
                end
                round_next = 4'd0;
            end
            aesbc_pkg::ST_KEY: begin
                // round 0 key is fetched in the first round state, after the last word is written
                if (ks_done) begin
                    state_next = aesbc_pkg::ST_ROUND;
                end
            end
            aesbc_pkg::ST_ROUND: begin
                round_next = round_reg + 4'd1;
                if (round_reg == nr + 4'd1) begin
                    state_next = aesbc_pkg::ST_DONE;
                end
            end
            aesbc_pkg::ST_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    state_next = aesbc_pkg::ST_IDLE;
                end
            end
            default: state_next = aesbc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl.decrypt = dir_reg;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.last    = 1'b0;
        res_load     = 1'b0;
        mvalid_next  = mvalid_reg && !m_ready;
        case (state_reg)
            aesbc_pkg::ST_ROUND: begin
                // key for round r-1 is registered now
                ctrl.load = (round_reg == 4'd1);
                ctrl.step = (round_reg > 4'd1);
                ctrl.last = (round_reg == nr + 4'd1);
            end
            aesbc_pkg::ST_DONE: begin
                // output register free or emptied at this edge
                if (!mvalid_reg || m_ready) begin
                    res_load    = 1'b1;
                    mvalid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= aesbc_pkg::ST_IDLE;
            round_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= {cols[3], cols[2], cols[1], cols[0]};
        end
    end

    // row shift: byte j of column c comes from column c+j (enc) or c-j (dec)
    always_comb begin
        for (int c = 0; c < aesbc_pkg::NumCells; c++) begin
            for (int j = 0; j < 4; j++) begin
                shifted[c][8*j +: 8] = dir_reg ? cols[(c + 4 - j) % 4][8*j +: 8]
                                               : cols[(c + j) % 4][8*j +: 8];
            end
        end
    end

    for (genvar c = 0; c < aesbc_pkg::NumCells; c++) begin : g_cell
        aesbc_column_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .load_word (blk_reg[32*c +: 32]),
            .shifted   (shifted[c]),
            .key_word  (rk[32*c +: 32]),
            .col       (cols[c])
        );
    end

    assign m_valid = mvalid_reg;
    assign m_data  = res_reg;

endmodule

// File: design/aesbc_key_sched.sv
// ----------------------------------------------------------------------------
// aesbc_key_sched
// Forward key expansion, one 32-bit word per cycle, into a round key memory.
// Read port indexed by round; inverse-mixed for middle decryption rounds.
// ----------------------------------------------------------------------------
module aesbc_key_sched (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [1:0]   key_length,
    input  logic         decrypt,
    input  logic [3:0]   rd_round,
    output logic [127:0] rd_key,
    output logic         done
);

    logic [5:0]   idx_reg, idx_next;
    logic         busy_reg, busy_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [2:0]   pos_reg, pos_next;
    logic [255:0] win_reg, win_next;
    // one bank per key column, addressed by round
    logic [31:0]  mem [4][16];
    logic [127:0] rd_raw_reg;
    logic         mix_reg;
    logic [3:0]   nr;
    logic [3:0]   nk;
    logic [5:0]   total;
    logic [31:0]  t, nw;
    logic [3:0]   phys_round;
    logic         wr_en;

    always_comb begin
        case (key_length)
            2'd0:    begin nk = 4'd4; nr = 4'd10; end
            2'd1:    begin nk = 4'd6; nr = 4'd12; end
            default: begin nk = 4'd8; nr = 4'd14; end
        endcase
        total = 6'({nr, 2'b00}) + 6'd4;
    end

    // win_reg holds the last nk words, newest at the top slot nk-1
    always_comb begin
        logic [31:0] prev, oldest;
        prev   = win_reg[32*(nk-4'd1) +: 32];
        oldest = win_reg[31:0];
        t = prev;
        if (pos_reg == 3'd0) begin
            t = aesbc_pkg::sub_word({prev[7:0], prev[31:8]}) ^ {24'd0, rcon_reg};
        end else if (nk == 4'd8 && pos_reg == 3'd4) begin
            t = aesbc_pkg::sub_word(prev);
        end
        nw = oldest ^ t;
    end

    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        rcon_next = rcon_reg;
        pos_next  = pos_reg;
        win_next  = win_reg;
        wr_en     = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = 6'd0;
            rcon_next = 8'h01;
            pos_next  = 3'd0;
            win_next  = key;
        end else if (busy_reg) begin
            wr_en = 1'b1;
            if (idx_reg >= 6'(nk)) begin
                win_next = win_reg >> 32;
                win_next[32*(nk-4'd1) +: 32] = nw;
                pos_next = (pos_reg == 3'(nk - 4'd1)) ? 3'd0 : pos_reg + 3'd1;
                if (pos_reg == 3'd0) begin
                    rcon_next = aesbc_pkg::xtime(rcon_reg);
                end
            end
            idx_next = idx_reg + 6'd1;
            if (idx_reg == total - 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        rcon_reg <= rcon_next;
        pos_reg  <= pos_next;
        win_reg  <= win_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg[1:0]][idx_reg[5:2]] <= (idx_reg < 6'(nk)) ?
                                               key[32*idx_reg[2:0] +: 32] : nw;
        end
    end

    assign done = busy_reg && idx_reg == total - 6'd1;

    assign phys_round = decrypt ? nr - rd_round : rd_round;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            rd_raw_reg[32*c +: 32] <= mem[c][phys_round];
        end
        mix_reg <= decrypt && rd_round != 4'd0 && rd_round != nr;
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (mix_reg) begin
                rd_key[32*c +: 32] = aesbc_pkg::inv_mix_word(rd_raw_reg[32*c +: 32]);
            end else begin
                rd_key[32*c +: 32] = rd_raw_reg[32*c +: 32];
            end
        end
    end

endmodule

// File: design/aesbc_column_cell.sv
// ----------------------------------------------------------------------------
// aesbc_column_cell
// One state column. Per round it hands its bytes to the neighbor columns
// through the row shift, substitutes, mixes (not in the last round) and adds its round key word.
// ----------------------------------------------------------------------------
module aesbc_column_cell (
    input  logic                   aclk,
    input  aesbc_pkg::cell_ctrl_t  ctrl,
    input  logic [31:0]            load_word,
    input  logic [31:0]            shifted,
    input  logic [31:0]            key_word,
    output logic [31:0]            col
);

    logic [31:0] col_reg, col_next;
    logic [31:0] sub, mixed;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            sub[8*j +: 8] = ctrl.decrypt ? aesbc_pkg::inv_sbox(shifted[8*j +: 8])
                                         : aesbc_pkg::sbox(shifted[8*j +: 8]);
        end
        if (ctrl.last) begin
            mixed = sub;
        end else if (ctrl.decrypt) begin
            mixed = aesbc_pkg::inv_mix_word(sub);
        end else begin
            mixed = aesbc_pkg::mix_word(sub);
        end
        col_next = col_reg;
        if (ctrl.load) begin
            col_next = load_word ^ key_word;
        end else if (ctrl.step) begin
            col_next = mixed ^ key_word;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

    assign col = col_reg;

endmodule

// File: sim/aes_block_cipher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_unit_tb
// Checks ECB encryption and decryption for 128, 192 and 256 bit keys against
// a behavioral AES cipher kept in the bench. Items are sent and drained with
// random idle bursts, one long output stall, and several key settings.
// ----------------------------------------------------------------------------
module aes_block_cipher_unit_tb;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    aesbc_pkg::in_item_t  s_data;
    logic                 m_valid;
    logic                 m_ready;
    aesbc_pkg::out_item_t m_data;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [63:0]          cfg_data;

    aes_block_cipher_unit dut (.*);

    logic [63:0]          key_reg [4];
    logic [1:0]           keylen_reg;
    logic                 decrypt_reg;
    aesbc_pkg::out_item_t expected_blocks [$];
    int                   fail_count;
    bit                   drain_idle;
    int                   hold_cycles;
    logic [7:0]           fwd_box [256];
    logic [7:0]           rev_box [256];

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = gf_dbl(a);
        end
        return r;
    endfunction

    // forward box built by GF inversion plus affine step, so it is independent
    function automatic logic [7:0] box_of(input logic [7:0] a);
        logic [7:0] inv, r;
        inv = 0;
        for (int c = 1; c < 256; c++) if (gf_mul(a, 8'(c)) == 8'h01) inv = 8'(c);
        r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return r;
    endfunction

    function automatic logic [31:0] unmix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] b [4];
        for (int j = 0; j < 4; j++) a[j] = w[8*j +: 8];
        for (int j = 0; j < 4; j++)
            b[j] = gf_mul(a[j], 8'h0e) ^ gf_mul(a[(j+1)%4], 8'h0b)
                 ^ gf_mul(a[(j+2)%4], 8'h0d) ^ gf_mul(a[(j+3)%4], 8'h09);
        return {b[3], b[2], b[1], b[0]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] b [4];
        for (int j = 0; j < 4; j++) a[j] = w[8*j +: 8];
        for (int j = 0; j < 4; j++)
            b[j] = gf_mul(a[j], 8'h02) ^ gf_mul(a[(j+1)%4], 8'h03) ^ a[(j+2)%4] ^ a[(j+3)%4];
        return {b[3], b[2], b[1], b[0]};
    endfunction

    function automatic aesbc_pkg::out_item_t cipher_block(input aesbc_pkg::in_item_t blk);
        logic [31:0]          w [60];
        logic [7:0]           s [16];
        logic [7:0]           t [16];
        logic [31:0]          tmp, col;
        logic [7:0]           rc;
        int                   nk, nr, len, k;
        aesbc_pkg::out_item_t res;
        len = (keylen_reg > 2) ? 2 : keylen_reg;
        nk = 4 + 2 * len;
        nr = 10 + 2 * len;
        rc = 8'h01;
        for (int i = 0; i < nk; i++) w[i] = key_reg[i/2][32*(i%2) +: 32];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            tmp = w[i-1];
            if (i % nk == 0) begin
                tmp = {tmp[7:0], tmp[31:8]};
                for (int j = 0; j < 4; j++) tmp[8*j +: 8] = fwd_box[tmp[8*j +: 8]];
                tmp ^= {24'h0, rc};
                rc = gf_dbl(rc);
            end else if (nk > 6 && i % nk == 4) begin
                for (int j = 0; j < 4; j++) tmp[8*j +: 8] = fwd_box[tmp[8*j +: 8]];
            end
            w[i] = w[i-nk] ^ tmp;
        end
        for (int i = 0; i < 8; i++) begin
            s[i] = blk.block_low[8*i +: 8];
            s[8+i] = blk.block_high[8*i +: 8];
        end
        // standard inverse cipher for decryption (equivalent result)
        k = decrypt_reg ? nr : 0;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) s[4*c+j] ^= w[4*k+c][8*j +: 8];
        for (int r = 1; r <= nr; r++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    t[4*c+j] = decrypt_reg ? rev_box[s[4*((c+4-j)%4)+j]]
                                           : fwd_box[s[4*((c+j)%4)+j]];
            k = decrypt_reg ? nr - r : r;
            for (int c = 0; c < 4; c++) begin
                col = {t[4*c+3], t[4*c+2], t[4*c+1], t[4*c]};
                if (decrypt_reg) begin
                    col ^= w[4*k+c];
                    if (r < nr) col = unmix_col(col);
                end else begin
                    if (r < nr) col = mix_col(col);
                    col ^= w[4*k+c];
                end
                for (int j = 0; j < 4; j++) s[4*c+j] = col[8*j +: 8];
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.result_low[8*i +: 8] = s[i];
            res.result_high[8*i +: 8] = s[8+i];
        end
        return res;
    endfunction

    task automatic write_reg(input aesbc_pkg::cfg_index_t idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            aesbc_pkg::REG_KEY0, aesbc_pkg::REG_KEY1,
            aesbc_pkg::REG_KEY2, aesbc_pkg::REG_KEY3: key_reg[idx[1:0]] = val;
            aesbc_pkg::REG_KEYLEN: keylen_reg = val[1:0];
            aesbc_pkg::REG_DIR: decrypt_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] len,
                            input logic dir);
        wait_idle();
        write_reg(aesbc_pkg::REG_KEY0, k0);
        write_reg(aesbc_pkg::REG_KEY1, k1);
        write_reg(aesbc_pkg::REG_KEY2, k2);
        write_reg(aesbc_pkg::REG_KEY3, k3);
        write_reg(aesbc_pkg::REG_KEYLEN, {62'd0, len});
        write_reg(aesbc_pkg::REG_DIR, {63'd0, dir});
        cfg_we <= 1'b0;
    endtask

    // valid stays up after an accept until the next item or an idle burst
    task automatic send_block(input logic [63:0] lo, hi, input bit gaps);
        aesbc_pkg::in_item_t blk;
        blk.block_low = lo;
        blk.block_high = hi;
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= blk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_blocks.push_back(cipher_block(blk));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                $error("result with nothing expected: %h", m_data);
                fail_count++;
            end else begin
                aesbc_pkg::out_item_t want;
                want = expected_blocks.pop_front();
                if (m_data.result_low !== want.result_low) begin
                    $error("result_low expected %h actual %h", want.result_low,
                           m_data.result_low);
                    fail_count++;
                end
                if (m_data.result_high !== want.result_high) begin
                    $error("result_high expected %h actual %h", want.result_high,
                           m_data.result_high);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold, none when draining
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (!drain_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_fips_vectors();
        // appendix C vectors, key 00..1f, plaintext 00112233..ff
        logic [63:0] k0, k1, k2, k3, p0, p1;
        k0 = 64'h0706050403020100; k1 = 64'h0f0e0d0c0b0a0908;
        k2 = 64'h1716151413121110; k3 = 64'h1f1e1d1c1b1a1918;
        p0 = 64'h7766554433221100; p1 = 64'hffeeddccbbaa9988;
        for (int len = 0; len < 4; len++)
            for (int dir = 0; dir < 2; dir++) begin
                load_key(k0, k1, k2, k3, len[1:0], dir[0]);
                send_block(p0, p1, 1'b0);
                send_block(64'd0, 64'd0, 1'b0);
                send_block('1, '1, 1'b0);
            end
    endtask

    task automatic test_key_extremes();
        load_key(64'd0, 64'd0, 64'd0, 64'd0, 2'd0, 1'b0);
        send_block(64'h8000000000000001, 64'h0000000000000080, 1'b0);
        load_key('1, '1, '1, '1, 2'd2, 1'b1);
        send_block('1, 64'd0, 1'b0);
        // bytes beyond the key length must not matter
        load_key('1, '1, 64'h0123456789abcdef, 64'hfedcba9876543210, 2'd0, 1'b0);
        send_block(64'h1, 64'h2, 1'b0);
    endtask

    task automatic test_backpressure();
        load_key(rand64(), rand64(), rand64(), rand64(), 2'd0, 1'b0);
        hold_cycles = 400;
        for (int i = 0; i < 8; i++) send_block(rand64(), rand64(), 1'b0);
    endtask

    task automatic test_random_blocks();
        for (int phase = 0; phase < 15; phase++) begin
            load_key(rand64(), rand64(), rand64(), rand64(), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
            if (phase == 12) drain_idle = 1'b1;
            for (int i = 0; i < 48; i++) send_block(rand64(), rand64(), !drain_idle);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        drain_idle = 1'b0;
        hold_cycles = 0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        keylen_reg = '0;
        decrypt_reg = 1'b0;
        for (int i = 0; i < 256; i++) fwd_box[i] = box_of(i[7:0]);
        for (int i = 0; i < 256; i++) rev_box[fwd_box[i]] = i[7:0];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fips_vectors();
        test_key_extremes();
        test_backpressure();
        test_random_blocks();
        wait_idle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
